// File: rtl/core/sgw_pkg.sv
package sgw_pkg;

    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 8;
    localparam int WSIZE_W = 4;
    localparam int IDX_W   = 4;   // window row/column index, 0..8
    localparam int HALF_W  = 3;   // half window k, 0..4
    localparam int WGT_W   = 6;   // signed kernel weight, -8..8
    localparam int GRAD_W  = 17;
    localparam int ABS_W   = 16;
    localparam int MAG_W   = 8;
    localparam int DIR_W   = 17;
    localparam int QUO_W   = 15;
    localparam int ANG_W   = 64;
    localparam int ROT_STEPS = 62;
    localparam int STEP_W  = 6;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd9;

    // tuser codes on the request side
    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [IDX_W-1:0]   size;
    } t_win_cmd;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    // long division, used only while building the angle table
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int bi = 63; bi >= 0; bi--) begin
            r = {r[63:0], a[bi]};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[bi] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q62
    function automatic logic [63:0] atan_recip(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] m2;
        logic [63:0] sum;
        logic [63:0] t;
        p   = udiv64(64'd1 << 62, m);
        m2  = m * m;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                t = udiv64(p, 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - t;
                else sum = sum + t;
                p = udiv64(p, m2);
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in Q62, i >= 1
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        logic        stop;
        int          e;
        sum  = '0;
        stop = 1'b0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (!stop) begin
                if (e > 62) begin
                    stop = 1'b1;
                end else begin
                    t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                    if (k % 2 == 1) sum = sum - t;
                    else sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] rot_angle(input int i);
        logic [63:0] a;
        if (i == 0) a = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
        else a = atan_pow2(i);
        return a;
    endfunction

    // position of the highest set bit of a nonzero value
    function automatic logic [4:0] msb16(input logic [ABS_W-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < ABS_W; b++) begin
            if (v[b]) p = 5'(b);
        end
        return p;
    endfunction

endpackage

// File: rtl/core/sobel_gradient_window_unit.sv
// Channel  | Dir | Handshake                 | Payload
// s (req)  | in  | i_s_tvalid / o_s_tready   | tuser: operation; tdata: col, row, pixel_value
// m (res)  | out | o_m_tvalid / i_m_tready   | tdata: magnitude, direction, grad_x, grad_y
// cfg      | in  | i_cfg_we                  | i_cfg_wdata: window_size
//
// Store request: written to the frame RAM at the edge that takes it.
// Compute request: window reads (one RAM read per cycle), then the magnitude and
// arctangent units in parallel; the arctangent unit (62 rotation steps, divide steps)
// sets the tail unless a gradient component is zero.
// Reset (i_rst_n low, synchronous) clears control and sets window_size to 9;
// the frame RAM is not cleared. A finished result waits in the output register
// while the next request is taken; a stalled result stalls only the next compute.
module sobel_gradient_window_unit #(
    parameter int FRAME_WIDTH  = sgw_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgw_pkg::FRAME_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,    // [0] operation
    input  logic [23:0] i_s_tdata,    // [7:0] col, [15:8] row, [23:16] pixel_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,    // [7:0] magnitude, [24:8] direction,
                                      // [41:25] grad_x, [58:42] grad_y
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata   // window_size
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WIN  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    localparam int CW = sgw_pkg::COORD_W;
    localparam int PW = sgw_pkg::PIX_W;

    logic [1:0]                       r_state;
    logic [sgw_pkg::WSIZE_W-1:0]      r_wsize;
    logic                             r_mag_ok, r_dir_ok;
    logic [sgw_pkg::MAG_W-1:0]        r_mag;
    logic signed [sgw_pkg::DIR_W-1:0] r_dir;
    sgw_pkg::t_grad                   r_grad;
    logic                             r_out_vld;
    logic [63:0]                      r_out_data;

    logic                             w_s_acc, w_store, w_start, w_load;
    logic [CW-1:0]                    w_col, w_row;
    logic [PW-1:0]                    w_pix;
    sgw_pkg::t_win_cmd                w_cmd;
    logic                             w_win_done, w_mag_done, w_dir_done;
    sgw_pkg::t_grad                   w_grad;
    logic [sgw_pkg::MAG_W-1:0]        w_mag;
    logic signed [sgw_pkg::DIR_W-1:0] w_dir;

    assign w_col = i_s_tdata[CW-1:0];
    assign w_row = i_s_tdata[2*CW-1:CW];
    assign w_pix = i_s_tdata[2*CW+PW-1:2*CW];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    // stores outside the frame are dropped
    assign w_store    = w_s_acc && (i_s_tuser == sgw_pkg::OP_STORE)
                      && (int'(w_col) < FRAME_WIDTH) && (int'(w_row) < FRAME_HEIGHT);
    assign w_start    = w_s_acc && (i_s_tuser == sgw_pkg::OP_COMPUTE);

    // odd sizes 5, 7, 9 are taken as they are; everything else is a 3x3 window
    assign w_cmd.col  = w_col;
    assign w_cmd.row  = w_row;
    assign w_cmd.size = (r_wsize == 4'd5 || r_wsize == 4'd7 || r_wsize == 4'd9)
                      ? r_wsize : 4'd3;

    assign w_load = (r_state == ST_POST) && r_mag_ok && r_dir_ok
                 && (!r_out_vld || i_m_tready);

    sgw_window #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_store),
        .i_wr_col (w_col),
        .i_wr_row (w_row),
        .i_wr_pix (w_pix),
        .i_start  (w_start),
        .i_cmd    (w_cmd),
        .o_done   (w_win_done),
        .o_grad   (w_grad)
    );

    sgw_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_win_done),
        .i_grad  (w_grad),
        .o_done  (w_mag_done),
        .o_mag   (w_mag)
    );

    sgw_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_win_done),
        .i_grad  (w_grad),
        .o_done  (w_dir_done),
        .o_dir   (w_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wsize   <= sgw_pkg::WSIZE_RESET;
            r_mag_ok  <= 1'b0;
            r_dir_ok  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_wsize <= i_cfg_wdata;

            unique case (r_state)
                ST_IDLE: if (w_start) r_state <= ST_WIN;
                ST_WIN: begin
                    if (w_win_done) begin
                        r_state  <= ST_POST;
                        r_mag_ok <= 1'b0;
                        r_dir_ok <= 1'b0;
                    end
                end
                ST_POST: begin
                    if (w_mag_done) r_mag_ok <= 1'b1;
                    if (w_dir_done) r_dir_ok <= 1'b1;
                    if (w_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_load) r_out_vld <= 1'b1;
            else if (i_m_tready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_win_done) r_grad <= w_grad;
        if (w_mag_done) r_mag <= w_mag;
        if (w_dir_done) r_dir <= w_dir;
        if (w_load) begin
            r_out_data <= {5'b0, r_grad.gy, r_grad.gx, r_dir, r_mag};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

// File: rtl/core/sgw_window.sv
module sgw_window #(
    parameter int FRAME_WIDTH  = sgw_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgw_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [sgw_pkg::COORD_W-1:0]   i_wr_col,
    input  logic [sgw_pkg::COORD_W-1:0]   i_wr_row,
    input  logic [sgw_pkg::PIX_W-1:0]     i_wr_pix,
    input  logic                          i_start,
    input  sgw_pkg::t_win_cmd             i_cmd,
    output logic                          o_done,
    output sgw_pkg::t_grad                o_grad
);
    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(FRAME_WIDTH);
    localparam int RW    = $clog2(FRAME_HEIGHT);
    localparam int IW    = sgw_pkg::IDX_W;
    localparam int KW    = sgw_pkg::HALF_W;
    localparam int WW    = sgw_pkg::WGT_W;
    localparam int GW    = sgw_pkg::GRAD_W;
    localparam int SW    = 10;  // signed window coordinate before clamping

    logic [sgw_pkg::PIX_W-1:0] mem [DEPTH];

    logic                    r_run, r_rd_vld, r_rd_last, r_done;
    logic [IW-1:0]           r_i, r_j, r_n;
    logic [KW-1:0]           r_k;
    logic [sgw_pkg::COORD_W-1:0] r_col, r_row;
    logic signed [WW-1:0]    r_wx, r_wy;
    logic signed [GW-1:0]    r_gx, r_gy;
    logic [sgw_pkg::PIX_W-1:0] r_rdata;

    logic [AW-1:0]           w_wr_addr, w_rd_addr;
    logic signed [SW-1:0]    w_cx, w_cy;
    logic [CW-1:0]           w_px;
    logic [RW-1:0]           w_py;
    logic signed [WW-1:0]    w_d, w_e, w_ad, w_ae, w_h, w_v, w_wx, w_wy, w_kk;
    logic signed [WW+sgw_pkg::PIX_W:0] w_prod_x, w_prod_y;
    logic                    w_last;

    assign w_wr_addr = AW'(i_wr_row * FRAME_WIDTH) + AW'(i_wr_col);

    // clamp window coordinates to the frame
    assign w_cx = $signed({2'b00, r_col}) + $signed({{(SW-IW){1'b0}}, r_j})
                - $signed({{(SW-KW){1'b0}}, r_k});
    assign w_cy = $signed({2'b00, r_row}) + $signed({{(SW-IW){1'b0}}, r_i})
                - $signed({{(SW-KW){1'b0}}, r_k});
    assign w_px = (w_cx < 0) ? '0 :
                  (int'(w_cx) > FRAME_WIDTH - 1) ? CW'(FRAME_WIDTH - 1) : CW'(w_cx);
    assign w_py = (w_cy < 0) ? '0 :
                  (int'(w_cy) > FRAME_HEIGHT - 1) ? RW'(FRAME_HEIGHT - 1) : RW'(w_cy);
    assign w_rd_addr = AW'(w_py * FRAME_WIDTH) + AW'(w_px);

    // kernel weights for the current tap
    assign w_kk = $signed({{(WW-KW){1'b0}}, r_k});
    assign w_d  = $signed({{(WW-IW){1'b0}}, r_i}) - w_kk;
    assign w_e  = $signed({{(WW-IW){1'b0}}, r_j}) - w_kk;
    assign w_ad = (w_d < 0) ? -w_d : w_d;
    assign w_ae = (w_e < 0) ? -w_e : w_e;
    assign w_h  = w_ad + w_kk - w_ae;
    assign w_v  = w_ae + w_kk - w_ad;
    assign w_wx = (w_d < 0) ? -w_h : ((w_d > 0) ? w_h : '0);
    assign w_wy = (w_e < 0) ? -w_v : ((w_e > 0) ? w_v : '0);
    assign w_last = (r_i == r_n - 1'b1) && (r_j == r_n - 1'b1);

    assign w_prod_x = r_wx * $signed({1'b0, r_rdata});
    assign w_prod_y = r_wy * $signed({1'b0, r_rdata});

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[w_wr_addr] <= i_wr_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= r_rd_vld && r_rd_last;
            if (i_start) begin
                r_run    <= 1'b1;
                r_rd_vld <= 1'b0;
            end else if (r_run) begin
                r_rd_vld  <= 1'b1;
                r_rd_last <= w_last;
                if (w_last) r_run <= 1'b0;
            end else begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i   <= '0;
            r_j   <= '0;
            r_n   <= i_cmd.size;
            r_k   <= KW'(i_cmd.size >> 1);
            r_col <= i_cmd.col;
            r_row <= i_cmd.row;
            r_gx  <= '0;
            r_gy  <= '0;
        end else begin
            if (r_run) begin
                r_wx <= w_wx;
                r_wy <= w_wy;
                if (r_j == r_n - 1'b1) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_rd_vld) begin
                r_gx <= r_gx + GW'(w_prod_x);
                r_gy <= r_gy + GW'(w_prod_y);
            end
        end
    end

    assign o_done    = r_done;
    assign o_grad.gx = r_gx;
    assign o_grad.gy = r_gy;

endmodule

// File: rtl/core/sgw_mag.sv
module sgw_mag (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  sgw_pkg::t_grad              i_grad,
    output logic                        o_done,
    output logic [sgw_pkg::MAG_W-1:0]   o_mag
);
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQ   = 2'd1;
    localparam logic [1:0] M_SUM  = 2'd2;
    localparam logic [1:0] M_ITER = 2'd3;

    localparam int AB = sgw_pkg::ABS_W;
    localparam int MW = sgw_pkg::MAG_W;

    logic [1:0]        r_state;
    logic              r_done;
    logic [AB-1:0]     r_ax, r_ay;
    logic [2*AB-1:0]   r_ax2, r_ay2;
    logic [2*AB:0]     r_s;
    logic [MW-1:0]     r_m;
    logic [2:0]        r_cnt;
    logic [MW-1:0]     w_t;
    logic [2*MW-1:0]   w_t2;

    assign w_t  = r_m | (MW'(1) << r_cnt);
    assign w_t2 = {{MW{1'b0}}, w_t} * {{MW{1'b0}}, w_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: if (i_start) r_state <= M_SQ;
                M_SQ:   r_state <= M_SUM;
                M_SUM:  r_state <= M_ITER;
                M_ITER: begin
                    if (r_cnt == 3'd0) begin
                        r_state <= M_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                r_ax <= i_grad.gx[sgw_pkg::GRAD_W-1] ? AB'(-i_grad.gx) : AB'(i_grad.gx);
                r_ay <= i_grad.gy[sgw_pkg::GRAD_W-1] ? AB'(-i_grad.gy) : AB'(i_grad.gy);
            end
            M_SQ: begin
                r_ax2 <= r_ax * r_ax;
                r_ay2 <= r_ay * r_ay;
            end
            M_SUM: begin
                r_s   <= {1'b0, r_ax2} + {1'b0, r_ay2};
                r_m   <= '0;
                r_cnt <= 3'd7;
            end
            M_ITER: begin
                // one result bit per cycle, top bit first
                if ({{(AB+1){1'b0}}, w_t2} <= r_s) r_m <= w_t;
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_m;

endmodule

// File: rtl/core/sgw_angle.sv
module sgw_angle (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  sgw_pkg::t_grad                     i_grad,
    output logic                               o_done,
    output logic signed [sgw_pkg::DIR_W-1:0]   o_dir
);
    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_PREP = 3'd1;
    localparam logic [2:0] A_ROT  = 3'd2;
    localparam logic [2:0] A_DIV0 = 3'd3;
    localparam logic [2:0] A_DIV1 = 3'd4;
    localparam logic [2:0] A_DIVN = 3'd5;
    localparam logic [2:0] A_RND  = 3'd6;
    localparam logic [2:0] A_FIX  = 3'd7;

    localparam int AB = sgw_pkg::ABS_W;
    localparam int NW = sgw_pkg::ANG_W;
    localparam int QW = sgw_pkg::QUO_W;
    localparam int DW = sgw_pkg::DIR_W;
    localparam int TW = sgw_pkg::STEP_W;
    localparam int NORM_TOP   = 59;
    localparam int FRAC_STEPS = 13;
    localparam int HALF_TURN  = 32768;
    localparam int QTR_TURN   = 16384;
    localparam logic [NW-1:0] QUARTER = sgw_pkg::rot_angle(0);

    logic [NW-1:0] w_tab [sgw_pkg::ROT_STEPS];

    for (genvar g = 0; g < sgw_pkg::ROT_STEPS; g++) begin : g_tab
        localparam logic [NW-1:0] ANG = sgw_pkg::rot_angle(g);
        assign w_tab[g] = ANG;
    end

    logic [2:0]          r_state;
    logic                r_done;
    logic                r_neg_x, r_neg_y, r_swap;
    logic [AB-1:0]       r_ax, r_ay;
    logic [NW-1:0]       r_x, r_y, r_z, r_r;
    logic [QW-1:0]       r_q;
    logic [TW-1:0]       r_step;
    logic signed [DW-1:0] r_dir;

    logic                w_swap;
    logic [AB-1:0]       w_hi, w_lo;
    logic [TW-1:0]       w_sh;
    logic [NW-1:0]       w_xs, w_ys, w_r0, w_r2;
    logic signed [DW-1:0] w_u0, w_u1, w_u2, w_u3;

    assign w_swap = r_ay > r_ax;
    assign w_hi   = w_swap ? r_ay : r_ax;
    assign w_lo   = w_swap ? r_ax : r_ay;
    assign w_sh   = TW'(NORM_TOP) - TW'(sgw_pkg::msb16(w_hi));

    assign w_xs = r_x >> r_step;
    assign w_ys = NW'($signed(r_y) >>> r_step);
    assign w_r0 = r_z[NW-1] ? '0 : r_z;
    assign w_r2 = r_r << 1;

    assign w_u0 = DW'(r_q);
    assign w_u1 = r_swap  ? DW'(QTR_TURN) - w_u0 : w_u0;
    assign w_u2 = r_neg_x ? DW'(HALF_TURN) - w_u1 : w_u1;
    assign w_u3 = r_neg_y ? -w_u2 : w_u2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: if (i_start) r_state <= A_PREP;
                A_PREP: begin
                    if (r_ax == '0 && r_ay == '0) begin
                        r_state <= A_IDLE;
                        r_done  <= 1'b1;
                    end else if (w_lo == '0) begin
                        r_state <= A_FIX;
                    end else begin
                        r_state <= A_ROT;
                    end
                end
                A_ROT:  if (r_step == TW'(sgw_pkg::ROT_STEPS - 1)) r_state <= A_DIV0;
                A_DIV0: r_state <= A_DIV1;
                A_DIV1: r_state <= A_DIVN;
                A_DIVN: if (r_step == TW'(FRAC_STEPS - 1)) r_state <= A_RND;
                A_RND:  r_state <= A_FIX;
                A_FIX: begin
                    r_state <= A_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                r_neg_x <= i_grad.gx[sgw_pkg::GRAD_W-1];
                r_neg_y <= i_grad.gy[sgw_pkg::GRAD_W-1];
                r_ax <= i_grad.gx[sgw_pkg::GRAD_W-1] ? AB'(-i_grad.gx) : AB'(i_grad.gx);
                r_ay <= i_grad.gy[sgw_pkg::GRAD_W-1] ? AB'(-i_grad.gy) : AB'(i_grad.gy);
                r_dir <= '0;
            end
            A_PREP: begin
                // bring the larger leg up to bit 59 in one shift
                r_swap <= w_swap;
                r_x    <= NW'(w_hi) << w_sh;
                r_y    <= NW'(w_lo) << w_sh;
                r_z    <= '0;
                r_q    <= '0;
                r_step <= '0;
            end
            A_ROT: begin
                if (!r_y[NW-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_tab[r_step];
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_tab[r_step];
                end
                r_step <= r_step + 1'b1;
            end
            A_DIV0: begin
                if (w_r0 >= QUARTER) begin
                    r_q <= QW'(1);
                    r_r <= w_r0 - QUARTER;
                end else begin
                    r_q <= '0;
                    r_r <= w_r0;
                end
                r_step <= '0;
            end
            A_DIV1: begin
                if (r_r >= QUARTER) r_r <= QUARTER - 1'b1;
            end
            A_DIVN: begin
                if (w_r2 >= QUARTER) begin
                    r_q <= {r_q[QW-2:0], 1'b1};
                    r_r <= w_r2 - QUARTER;
                end else begin
                    r_q <= {r_q[QW-2:0], 1'b0};
                    r_r <= w_r2;
                end
                r_step <= r_step + 1'b1;
            end
            A_RND: begin
                if (w_r2 >= QUARTER) r_q <= r_q + 1'b1;
            end
            A_FIX: begin
                r_dir <= w_u3;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_dir  = r_dir;

endmodule

// File: rtl/core/sgw_checker.sv
module sgw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic [23:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        i_cfg_we,
    input logic [3:0]  i_cfg_wdata
);
    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result payload changed under stall");

    // a compute request blocks the request side once it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == sgw_pkg::OP_COMPUTE) |=> !o_s_tready)
        else $error("request taken while a compute is running");

    // a new result only follows a running compute
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result without compute");

    // zero gradient gives zero magnitude and direction
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[41:25] == 17'd0) && (o_m_tdata[58:42] == 17'd0)
        |-> (o_m_tdata[7:0] == 8'd0) && (o_m_tdata[24:8] == 17'd0))
        else $error("nonzero magnitude or direction at zero gradient");

endmodule

bind sobel_gradient_window_unit sgw_checker u_sgw_checker (.*);
